[hdl/tile_glyph_row_blitter_macros.svh]
// ----------------------------------------------------------------------------
// Glyph row blitter assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef TILE_GLYPH_ROW_BLITTER_MACROS_SVH
`define TILE_GLYPH_ROW_BLITTER_MACROS_SVH

`ifndef SYNTHESIS
// Condition holds at every edge out of reset
`define TGRB_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent implies consequent in the same cycle
`define TGRB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle
`define TGRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TGRB_ASSERT_HOLDS(label, clk, rst_n, cond, msg)
`define TGRB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TGRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[hdl/tgrb_pkg.sv]
// ----------------------------------------------------------------------------
// Glyph row blitter package
// Shared widths, register indexes, span job type and a helper function.
// ----------------------------------------------------------------------------
package tgrb_pkg;

    // Defaults for the top level parameters
    localparam int FRAME_WIDTH_DEF     = 1024;
    localparam int FRAME_HEIGHT_DEF    = 1024;
    localparam int GLYPH_WIDTH_DEF     = 8;
    localparam int MAX_PIXEL_SCALE_DEF = 8;

    // Fixed geometry
    localparam int GLYPH_MAX   = 8;
    localparam int GLYPH_ROWS  = 8;
    localparam int PIX_W       = 3;
    localparam int QUEUE_DEPTH = 4;

    // Field widths
    localparam int BITS_W   = 8;
    localparam int ROWIDX_W = 3;
    localparam int TILE_W   = 13;
    localparam int SCALE_W  = 4;
    localparam int COLOR_W  = 32;
    localparam int ADDR_W   = 20;
    localparam int LEN_W    = 4;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int COL_W    = CFG_W;
    localparam int ROW_W    = CFG_W;
    localparam int XSC_W    = 7;
    localparam int EXT_W    = 13;
    localparam int POS_W    = 22;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 2'd3;

    localparam logic [CFG_W-1:0] CLIP_RIGHT_RST  = 11'd1024;
    localparam logic [CFG_W-1:0] CLIP_BOTTOM_RST = 11'd1024;

    // One classified glyph row: visible pixels and the sub-rows to draw
    typedef struct packed {
        logic [GLYPH_MAX-1:0]            vis;
        logic [GLYPH_MAX-1:0]            on;
        logic [GLYPH_MAX-1:0][COL_W-1:0] x0;
        logic [GLYPH_MAX-1:0][LEN_W-1:0] len;
        logic [SCALE_W-1:0]              rows;
        logic [ADDR_W-1:0]               row_base;
        logic [COLOR_W-1:0]              fg;
        logic [COLOR_W-1:0]              bg;
    } span_job_t;

    // Index of the leftmost pixel still pending
    function automatic logic [PIX_W-1:0] first_set(input logic [GLYPH_MAX-1:0] m);
        logic [PIX_W-1:0] idx;
        idx = '0;
        for (int i = GLYPH_MAX - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                idx = PIX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[hdl/tgrb_if.sv]
// ----------------------------------------------------------------------------
// Glyph row blitter channels
// Valid/ready channels for glyph rows in and frame buffer spans out.
// ----------------------------------------------------------------------------
interface tgrb_in_if import tgrb_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [BITS_W-1:0]          row_bits;
    logic [ROWIDX_W-1:0]        row_index;
    logic signed [TILE_W-1:0]   tile_x;
    logic signed [TILE_W-1:0]   tile_y;
    logic                       grid;
    logic                       transparent;
    logic [SCALE_W-1:0]         pixel_width;
    logic [SCALE_W-1:0]         pixel_height;
    logic [COLOR_W-1:0]         fg_color;
    logic [COLOR_W-1:0]         bg_color;

    modport source (
        output valid, row_bits, row_index, tile_x, tile_y, grid, transparent,
               pixel_width, pixel_height, fg_color, bg_color,
        input  ready
    );
    modport sink (
        input  valid, row_bits, row_index, tile_x, tile_y, grid, transparent,
               pixel_width, pixel_height, fg_color, bg_color,
        output ready
    );
endinterface

interface tgrb_out_if import tgrb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  write_address;
    logic [LEN_W-1:0]   span_length;
    logic [COLOR_W-1:0] color;
    logic               last;

    modport source (
        output valid, write_address, span_length, color, last,
        input  ready
    );
    modport sink (
        input  valid, write_address, span_length, color, last,
        output ready
    );
endinterface

[hdl/tgrb_front.sv]
// ----------------------------------------------------------------------------
// Glyph row blitter front end
// Holds the clip registers, takes glyph rows and classifies them over four
// stages into span jobs; rows that draw nothing are dropped here.
// ----------------------------------------------------------------------------
module tgrb_front import tgrb_pkg::*; #(
    parameter int FRAME_WIDTH     = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT    = FRAME_HEIGHT_DEF,
    parameter int GLYPH_WIDTH     = GLYPH_WIDTH_DEF,
    parameter int MAX_PIXEL_SCALE = MAX_PIXEL_SCALE_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    tgrb_in_if.sink              glyph,
    output span_job_t            job,
    output logic                 job_valid,
    input  logic                 job_full
);

    localparam logic [SCALE_W-1:0] MAX_SCALE = SCALE_W'(MAX_PIXEL_SCALE);

    // Clip registers
    logic [CFG_W-1:0] clip_left_reg, clip_top_reg, clip_right_reg, clip_bottom_reg;
    logic [CFG_W-1:0] right_eff, bottom_eff;
    logic signed [POS_W-1:0] left_w, top_w, right_w, bottom_w;

    // Stage handshake
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic en1, en2, en3, en4;

    // Stage 1
    logic [SCALE_W-1:0]      pw_sat, ph_sat;
    logic [XSC_W-1:0]        xs, ys;
    logic signed [POS_W-1:0] xprod_next, yprod_next;
    logic [GLYPH_MAX-1:0]    on_next, draw_next;
    logic signed [POS_W-1:0] s1_xprod_reg, s1_yprod_reg;
    logic [SCALE_W-1:0]      s1_pw_reg, s1_ph_reg;
    logic [GLYPH_MAX-1:0]    s1_on_reg, s1_draw_reg;
    logic [COLOR_W-1:0]      s1_fg_reg, s1_bg_reg;

    // Stage 2
    logic signed [POS_W-1:0] base, neg_y, dist_y, y_next;
    logic signed [POS_W-1:0] ph_w;
    logic signed [POS_W-1:0] p_next [GLYPH_WIDTH+1];
    logic [SCALE_W-1:0]      sy_first_next, sy_end_next;
    logic signed [POS_W-1:0] s2_p_reg [GLYPH_WIDTH+1];
    logic signed [POS_W-1:0] s2_y_reg;
    logic [SCALE_W-1:0]      s2_sy_first_reg, s2_sy_end_reg;
    logic [GLYPH_MAX-1:0]    s2_on_reg, s2_draw_reg;
    logic [COLOR_W-1:0]      s2_fg_reg, s2_bg_reg;

    // Stage 3
    span_job_t               job3_next;
    logic [ROW_W-1:0]        py_next;
    logic                    keep_next;
    logic signed [POS_W-1:0] lo, hi;
    span_job_t               s3_job_reg;
    logic [ROW_W-1:0]        s3_py_reg;
    logic                    s3_keep_reg;

    // Stage 4
    span_job_t               job4_next;
    span_job_t               s4_job_reg;

    // Write clip registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_right_reg  <= CLIP_RIGHT_RST;
            clip_bottom_reg <= CLIP_BOTTOM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CLIP_LEFT:   clip_left_reg   <= cfg_data;
                REG_CLIP_TOP:    clip_top_reg    <= cfg_data;
                REG_CLIP_RIGHT:  clip_right_reg  <= cfg_data;
                REG_CLIP_BOTTOM: clip_bottom_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Limit the clip box to the frame
    always_comb
    begin
        right_eff  = (EXT_W'(clip_right_reg) > EXT_W'(FRAME_WIDTH)) ?
                     CFG_W'(FRAME_WIDTH) : clip_right_reg;
        bottom_eff = (EXT_W'(clip_bottom_reg) > EXT_W'(FRAME_HEIGHT)) ?
                     CFG_W'(FRAME_HEIGHT) : clip_bottom_reg;
        left_w     = $signed(POS_W'(clip_left_reg));
        top_w      = $signed(POS_W'(clip_top_reg));
        right_w    = $signed(POS_W'(right_eff));
        bottom_w   = $signed(POS_W'(bottom_eff));
    end

    // Advance a stage when it is empty or the next one moves
    assign en4         = !s4_valid_reg || !job_full;
    assign en3         = !s3_valid_reg || en4;
    assign en2         = !s2_valid_reg || en3;
    assign en1         = !s1_valid_reg || en2;
    assign glyph.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= glyph.valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg && s3_keep_reg;
            end
        end
    end

    // Stage 1: saturate scales, form the scaled tile origin
    always_comb
    begin
        pw_sat = (glyph.pixel_width > MAX_SCALE) ? MAX_SCALE : glyph.pixel_width;
        ph_sat = (glyph.pixel_height > MAX_SCALE) ? MAX_SCALE : glyph.pixel_height;
        xs = glyph.grid ? XSC_W'(pw_sat) * XSC_W'(GLYPH_WIDTH) : XSC_W'(pw_sat);
        ys = glyph.grid ? XSC_W'(ph_sat) * XSC_W'(GLYPH_ROWS) : XSC_W'(ph_sat);
        xprod_next = POS_W'(glyph.tile_x) * $signed(POS_W'(xs));
        yprod_next = POS_W'(glyph.tile_y) * $signed(POS_W'(ys))
                   + $signed(POS_W'(glyph.row_index)) * $signed(POS_W'(ph_sat));
        on_next   = '0;
        draw_next = '0;
        for (int i = 0; i < GLYPH_WIDTH; i++)
        begin
            on_next[i]   = glyph.row_bits[GLYPH_WIDTH-1-i];
            draw_next[i] = glyph.row_bits[GLYPH_WIDTH-1-i] || !glyph.transparent;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_xprod_reg <= xprod_next;
            s1_yprod_reg <= yprod_next;
            s1_pw_reg    <= pw_sat;
            s1_ph_reg    <= ph_sat;
            s1_on_reg    <= on_next;
            s1_draw_reg  <= draw_next;
            s1_fg_reg    <= glyph.fg_color;
            s1_bg_reg    <= glyph.bg_color;
        end
    end

    // Stage 2: pixel edges and the range of sub-rows inside the clip box
    always_comb
    begin
        base = s1_xprod_reg + left_w;
        for (int k = 0; k <= GLYPH_WIDTH; k++)
        begin
            p_next[k] = base + $signed(POS_W'(k)) * $signed(POS_W'(s1_pw_reg));
        end
        ph_w   = $signed(POS_W'(s1_ph_reg));
        y_next = s1_yprod_reg + top_w;
        neg_y  = -s1_yprod_reg;
        dist_y = bottom_w - y_next;
        if (s1_yprod_reg >= 0)
        begin
            sy_first_next = '0;
        end
        else if (neg_y >= ph_w)
        begin
            sy_first_next = s1_ph_reg;
        end
        else
        begin
            sy_first_next = neg_y[SCALE_W-1:0];
        end
        if (dist_y <= 0)
        begin
            sy_end_next = '0;
        end
        else if (dist_y >= ph_w)
        begin
            sy_end_next = s1_ph_reg;
        end
        else
        begin
            sy_end_next = dist_y[SCALE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_p_reg        <= p_next;
            s2_y_reg        <= y_next;
            s2_sy_first_reg <= sy_first_next;
            s2_sy_end_reg   <= sy_end_next;
            s2_on_reg       <= s1_on_reg;
            s2_draw_reg     <= s1_draw_reg;
            s2_fg_reg       <= s1_fg_reg;
            s2_bg_reg       <= s1_bg_reg;
        end
    end

    // Stage 3: clip each pixel, keep rows that draw something
    always_comb
    begin
        job3_next          = '0;
        job3_next.on       = s2_on_reg;
        job3_next.fg       = s2_fg_reg;
        job3_next.bg       = s2_bg_reg;
        job3_next.rows     = s2_sy_end_reg - s2_sy_first_reg;
        lo                 = '0;
        hi                 = '0;
        for (int i = 0; i < GLYPH_WIDTH; i++)
        begin
            lo = (s2_p_reg[i] < left_w) ? left_w : s2_p_reg[i];
            hi = (s2_p_reg[i+1] > right_w) ? right_w : s2_p_reg[i+1];
            job3_next.vis[i] = s2_draw_reg[i] && (lo < hi);
            job3_next.x0[i]  = COL_W'(lo);
            job3_next.len[i] = LEN_W'(hi - lo);
        end
        py_next   = ROW_W'(s2_y_reg + $signed(POS_W'(s2_sy_first_reg)));
        keep_next = (s2_sy_end_reg > s2_sy_first_reg) && (|job3_next.vis);
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_job_reg  <= job3_next;
            s3_py_reg   <= py_next;
            s3_keep_reg <= keep_next;
        end
    end

    // Stage 4: frame address of the first visible sub-row
    always_comb
    begin
        job4_next          = s3_job_reg;
        job4_next.row_base = ADDR_W'(s3_py_reg) * ADDR_W'(FRAME_WIDTH);
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_job_reg <= job4_next;
        end
    end

    assign job       = s4_job_reg;
    assign job_valid = s4_valid_reg;

endmodule

[hdl/tgrb_queue.sv]
// ----------------------------------------------------------------------------
// Glyph row blitter job queue
// Short first-in first-out store of span jobs between front and back end.
// ----------------------------------------------------------------------------
module tgrb_queue import tgrb_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    input  span_job_t push_data,
    output logic      full,
    input  logic      pop,
    output span_job_t head,
    output logic      empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);

    span_job_t        mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pull;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign push  = push_valid && !full;
    assign pull  = pop && !empty;
    assign head  = mem[rd_ptr_reg];

    // Store a job on push
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and track fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pull)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pull)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pull && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hdl/tgrb_back.sv]
// ----------------------------------------------------------------------------
// Glyph row blitter back end
// Walks the visible pixels of a job and their sub-rows, one span per cycle
// unless the output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
`include "tile_glyph_row_blitter_macros.svh"

module tgrb_back import tgrb_pkg::*; #(
    parameter int FRAME_WIDTH = FRAME_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  span_job_t head,
    input  logic      q_empty,
    output logic      pop,
    tgrb_out_if.source span
);

    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(FRAME_WIDTH);

    span_job_t            cur_job_reg;
    logic                 active_reg;
    logic [GLYPH_MAX-1:0] mask_reg;
    logic [SCALE_W-1:0]   rows_left_reg;
    logic [ADDR_W-1:0]    row_addr_reg;

    logic                 out_valid_reg;
    logic [ADDR_W-1:0]    out_addr_reg;
    logic [LEN_W-1:0]     out_len_reg;
    logic [COLOR_W-1:0]   out_color_reg;
    logic                 out_last_reg;

    logic [PIX_W-1:0]     cur;
    logic [GLYPH_MAX-1:0] mask_after;
    logic                 row_done, last_span, adv, emit, finishing, load;

    // Pick the pending pixel and see whether this span closes the job
    always_comb
    begin
        cur        = first_set(mask_reg);
        mask_after = mask_reg & ~(GLYPH_MAX'(1) << cur);
        row_done   = (rows_left_reg == SCALE_W'(1));
        last_span  = row_done && (mask_after == '0);
        adv        = !out_valid_reg || span.ready;
        emit       = active_reg && adv;
        finishing  = emit && last_span;
        load       = !q_empty && (!active_reg || finishing);
    end

    assign pop = load;

    // Step through sub-rows, then pixels; take the next job on the last span
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            mask_reg      <= '0;
            rows_left_reg <= '0;
        end
        else if (load)
        begin
            active_reg    <= 1'b1;
            mask_reg      <= head.vis;
            rows_left_reg <= head.rows;
        end
        else if (emit)
        begin
            if (row_done)
            begin
                mask_reg      <= mask_after;
                rows_left_reg <= cur_job_reg.rows;
                if (mask_after == '0)
                begin
                    active_reg <= 1'b0;
                end
            end
            else
            begin
                rows_left_reg <= rows_left_reg - 1'b1;
            end
        end
    end

    // Hold the job payload and the running row address
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_job_reg  <= head;
            row_addr_reg <= head.row_base;
        end
        else if (emit)
        begin
            row_addr_reg <= row_done ? cur_job_reg.row_base : row_addr_reg + ROW_STEP;
        end
    end

    // Output stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (span.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_addr_reg  <= row_addr_reg + ADDR_W'(cur_job_reg.x0[cur]);
            out_len_reg   <= cur_job_reg.len[cur];
            out_color_reg <= cur_job_reg.on[cur] ? cur_job_reg.fg : cur_job_reg.bg;
            out_last_reg  <= last_span;
        end
    end

    assign span.valid         = out_valid_reg;
    assign span.write_address = out_addr_reg;
    assign span.span_length   = out_len_reg;
    assign span.color         = out_color_reg;
    assign span.last          = out_last_reg;

    // An active job always has a pixel and a sub-row left
    `TGRB_ASSERT_HOLDS(a_active_mask, clk, rst_n, !active_reg || (mask_reg != '0), "active job with no pixel left")
    `TGRB_ASSERT_HOLDS(a_active_rows, clk, rst_n, !active_reg || (rows_left_reg != '0), "active job with no sub-row left")
    // Closing a job with nothing queued leaves the back end idle
    `TGRB_ASSERT_NEXT(a_finish_idle, clk, rst_n, finishing && q_empty, !active_reg, "back end busy after last span")

endmodule

[hdl/tile_glyph_row_blitter.sv]
// ----------------------------------------------------------------------------
// Tile glyph row blitter
// Turns glyph rows into clipped frame buffer spans.
// ----------------------------------------------------------------------------
// Each accepted glyph row produces one span per visible glyph pixel per
// visible scaled sub-row, pixels left to right and sub-rows top to bottom
// within a pixel, with last set on the final span of the row. The back end
// issues one span per clock unless the output stalls, up to GLYPH_WIDTH x
// MAX_PIXEL_SCALE = 64 per row; this span issue loop sets the sustained rate.
// The front end classifies one row per clock unless the queue is full, over
// four register stages, and drops rows that draw nothing; a four-entry job
// queue lets it keep taking rows while the back end is busy or a finished span
// waits in the output register. Clip registers must be written through
// cfg_we/cfg_index/cfg_data only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module tile_glyph_row_blitter import tgrb_pkg::*; #(
    parameter int FRAME_WIDTH     = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT    = FRAME_HEIGHT_DEF,
    parameter int GLYPH_WIDTH     = GLYPH_WIDTH_DEF,
    parameter int MAX_PIXEL_SCALE = MAX_PIXEL_SCALE_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    tgrb_in_if.sink              glyph,
    tgrb_out_if.source           span
);

    span_job_t job, head;
    logic      job_valid, job_full, pop, q_empty;

    tgrb_front #(
        .FRAME_WIDTH     (FRAME_WIDTH),
        .FRAME_HEIGHT    (FRAME_HEIGHT),
        .GLYPH_WIDTH     (GLYPH_WIDTH),
        .MAX_PIXEL_SCALE (MAX_PIXEL_SCALE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .glyph     (glyph),
        .job       (job),
        .job_valid (job_valid),
        .job_full  (job_full)
    );

    tgrb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (job_valid),
        .push_data  (job),
        .full       (job_full),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty)
    );

    tgrb_back #(
        .FRAME_WIDTH (FRAME_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .span    (span)
    );

endmodule
